// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the date adder RTL.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GDAD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gdad assertion failed");
`define GDAD_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gdad reset assertion failed");
`else
`define GDAD_ASSERT(lbl, clk, rst_n, prop)
`define GDAD_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/gdad_pkg.sv
// Shared types, constants and month table for the Gregorian date adder.
// No dependencies.
package gdad_pkg;

  localparam int MONTH_W          = 4;
  localparam int DAY_W            = 5;
  localparam int YEAR_W           = 14;
  localparam int DAYS_W           = 16;
  localparam int DAY_COUNT_BITS_DEF = 16;
  localparam int IN_DATA_W        = 40;
  localparam int OUT_DATA_W       = 24;
  localparam int STEP_W           = 3;

  localparam int RECIP_SHIFT      = 19;
  localparam int RECIP_W          = 13;
  localparam int PROD_W           = YEAR_W + RECIP_W;
  localparam int QUOT_W           = PROD_W - RECIP_SHIFT;
  localparam int REM_W            = 7;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam logic [YEAR_W-1:0]  CENTURY   = 14'd100;
  localparam logic [REM_W-1:0]   REM_LAST  = 7'd99;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd16383;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SPLIT,
    OP_CHECK,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_ALWAYS,
    JC_IN_FIRE,
    JC_BAD,
    JC_MORE,
    JC_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic bad;
    logic more;
    logic out_free;
  } status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/gregorian_date_add_days.sv
// Gregorian date adder: moves a date forward by a day count, one month per step.
// An item steps through LOAD, SPLIT and CHECK, then one MONTH step for each month
// boundary crossed plus a final one (none for a bad date), then EMIT. A result
// waits in an output register, so the next item is taken while the previous
// result is still held.
// Depends on gdad_pkg, gdad_seq and assert_macros.svh.
`include "assert_macros.svh"

module gregorian_date_add_days #(
  parameter int DAY_COUNT_BITS = gdad_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gdad_pkg::IN_DATA_W-1:0]  in_tdata,   // month, day, year, days_to_add, pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gdad_pkg::OUT_DATA_W-1:0] out_tdata,  // out_month, out_day, out_year, pad
  output logic                            out_tuser   // bad_date
);

  localparam int CNT_W = (DAY_COUNT_BITS < gdad_pkg::DAYS_W) ?
                         DAY_COUNT_BITS : gdad_pkg::DAYS_W;
  localparam int MW = gdad_pkg::MONTH_W;
  localparam int DW = gdad_pkg::DAY_W;
  localparam int YW = gdad_pkg::YEAR_W;

  gdad_pkg::ctl_t    ctl;
  gdad_pkg::status_t stat;

  logic [MW-1:0]                 m_r;
  logic [DW-1:0]                 d_r;
  logic [YW-1:0]                 y_r;
  logic [CNT_W-1:0]              left_r;
  logic [gdad_pkg::PROD_W-1:0]   prod_r;
  logic [gdad_pkg::REM_W-1:0]    r100_r;
  logic [1:0]                    q4_r;
  logic                          bad_r;
  logic                          out_valid_r;
  logic [MW-1:0]                 out_month_r;
  logic [DW-1:0]                 out_day_r;
  logic [YW-1:0]                 out_year_r;
  logic                          out_bad_r;

  logic [MW-1:0]                 in_month;
  logic [DW-1:0]                 in_day;
  logic [YW-1:0]                 in_year;
  logic [gdad_pkg::QUOT_W-1:0]   quot;
  logic [YW-1:0]                 quot_x100;
  logic                          leap;
  logic [DW-1:0]                 len;
  logic [DW-1:0]                 rest;
  logic                          more;
  logic                          invalid;
  logic                          in_fire;
  logic                          out_free;

  gdad_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctl  (ctl)
  );

  assign in_month = in_tdata[MW-1:0];
  assign in_day   = in_tdata[MW +: DW];
  assign in_year  = in_tdata[MW+DW +: YW];

  assign in_tready = (ctl.op == gdad_pkg::OP_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign quot      = prod_r[gdad_pkg::PROD_W-1:gdad_pkg::RECIP_SHIFT];
  assign quot_x100 = YW'(quot) * gdad_pkg::CENTURY;

  assign leap    = (y_r[1:0] == 2'b00) && ((r100_r != '0) || (q4_r == 2'b00));
  assign len     = gdad_pkg::month_len(m_r, leap);
  assign invalid = (len == '0) || (d_r == '0) || (d_r > len);
  assign rest    = len - d_r;
  assign more    = left_r > CNT_W'(rest);

  assign stat.in_fire  = in_fire;
  assign stat.bad      = invalid;
  assign stat.more     = more;
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    case (ctl.op)
      gdad_pkg::OP_LOAD: begin
        if (in_fire) begin
          m_r    <= in_month;
          d_r    <= in_day;
          y_r    <= in_year;
          left_r <= in_tdata[MW+DW+YW +: CNT_W];
          prod_r <= gdad_pkg::PROD_W'(in_year) * gdad_pkg::PROD_W'(gdad_pkg::RECIP_100);
        end
      end
      gdad_pkg::OP_SPLIT: begin
        r100_r <= gdad_pkg::REM_W'(y_r - quot_x100);
        q4_r   <= quot[1:0];
      end
      gdad_pkg::OP_CHECK: begin
        bad_r <= invalid;
      end
      gdad_pkg::OP_MONTH: begin
        if (more) begin
          left_r <= left_r - CNT_W'(rest) - CNT_W'(1);
          d_r    <= DW'(1);
          if (m_r == gdad_pkg::MONTH_DEC) begin
            m_r <= gdad_pkg::MONTH_JAN;
            if (y_r == gdad_pkg::YEAR_MAX) begin
              y_r    <= '0;
              r100_r <= '0;
              q4_r   <= 2'b00;
            end else begin
              y_r <= y_r + YW'(1);
              if (r100_r == gdad_pkg::REM_LAST) begin
                r100_r <= '0;
                q4_r   <= q4_r + 2'b01;
              end else begin
                r100_r <= r100_r + gdad_pkg::REM_W'(1);
              end
            end
          end else begin
            m_r <= m_r + MW'(1);
          end
        end else begin
          d_r    <= d_r + left_r[DW-1:0];
          left_r <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.op == gdad_pkg::OP_EMIT && out_free) begin
      out_month_r <= m_r;
      out_day_r   <= d_r;
      out_year_r  <= y_r;
      out_bad_r   <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == gdad_pkg::OP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_year_r, out_day_r, out_month_r};
  assign out_tuser  = out_bad_r;

  `GDAD_ASSERT(a_leave_load, clk, rst_n, in_fire |=> !in_tready)
  `GDAD_ASSERT(a_count_spent, clk, rst_n,
    (ctl.op == gdad_pkg::OP_EMIT && !bad_r) |-> (left_r == '0))
  `GDAD_ASSERT(a_good_date, clk, rst_n,
    (out_tvalid && !out_tuser) |->
      (out_day_r != '0 && out_month_r != '0 && out_month_r <= gdad_pkg::MONTH_DEC))
  `GDAD_ASSERT(a_emit_loads, clk, rst_n,
    (ctl.op == gdad_pkg::OP_EMIT && out_free) |=> out_tvalid)
  `GDAD_ASSERT_RST(a_reset_idle, clk, !rst_n |=> (!out_tvalid && in_tready))

endmodule

// File: hw/rtl/gdad_seq.sv
// Microcode sequencer for the date adder: step counter and control ROM.
// Depends on gdad_pkg.
module gdad_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  gdad_pkg::status_t stat,
  output gdad_pkg::ctl_t    ctl
);

  localparam gdad_pkg::uword_t ROM [5] = '{
    '{op: gdad_pkg::OP_LOAD,  cond: gdad_pkg::JC_IN_FIRE,  t_true: 3'd1, t_false: 3'd0},
    '{op: gdad_pkg::OP_SPLIT, cond: gdad_pkg::JC_ALWAYS,   t_true: 3'd2, t_false: 3'd2},
    '{op: gdad_pkg::OP_CHECK, cond: gdad_pkg::JC_BAD,      t_true: 3'd4, t_false: 3'd3},
    '{op: gdad_pkg::OP_MONTH, cond: gdad_pkg::JC_MORE,     t_true: 3'd3, t_false: 3'd4},
    '{op: gdad_pkg::OP_EMIT,  cond: gdad_pkg::JC_OUT_FREE, t_true: 3'd0, t_false: 3'd4}
  };

  gdad_pkg::step_t  step_r;
  gdad_pkg::step_t  step_nxt;
  gdad_pkg::uword_t uw;
  logic             take;

  always_comb begin
    if (step_r < gdad_pkg::STEP_W'(5)) begin
      uw = ROM[step_r];
    end else begin
      uw = ROM[0];
    end
  end

  always_comb begin
    unique case (uw.cond)
      gdad_pkg::JC_ALWAYS:   take = 1'b1;
      gdad_pkg::JC_IN_FIRE:  take = stat.in_fire;
      gdad_pkg::JC_BAD:      take = stat.bad;
      gdad_pkg::JC_MORE:     take = stat.more;
      gdad_pkg::JC_OUT_FREE: take = stat.out_free;
      default:               take = 1'b1;
    endcase
    step_nxt = take ? uw.t_true : uw.t_false;
    ctl.op   = uw.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
